// ===== sv/cau_pkg.sv =====
// shared types and constants for the complex arithmetic unit
package cau_pkg;

  localparam int WIDTH    = 16;
  localparam int FRAC_MAX = WIDTH;
  localparam int MW       = 2 * WIDTH;
  localparam int NW       = MW + FRAC_MAX;

  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [WIDTH-1:0] a_re;
    logic signed [WIDTH-1:0] a_im;
    logic signed [WIDTH-1:0] b_re;
    logic signed [WIDTH-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] res_re;
    logic signed [WIDTH-1:0] res_im;
    logic                    saturated;
    logic                    div_zero;
  } cau_out_t;

  typedef struct packed {
    logic             neg;
    logic             over;
    logic [MW:0]      rem;
    logic [WIDTH-1:0] num;
    logic [WIDTH-1:0] quo;
    logic [MW-1:0]    mag;
  } cau_lane_t;

  typedef struct packed {
    logic [1:0]    func;
    logic          dz;
    logic [MW-1:0] den;
    cau_lane_t     re;
    cau_lane_t     im;
  } cau_work_t;

endpackage

// ===== sv/cau_prep.sv =====
// front stages: products, signed sums, magnitudes and divider setup
module cau_prep #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  cau_pkg::cau_in_t  in_data,
  output logic              out_valid,
  output cau_pkg::cau_work_t out_work
);
  import cau_pkg::*;

  // stage 1 registers
  logic                    v1_r;
  logic [1:0]              f1_r;
  logic signed [MW-1:0]    p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb1_r, p_bb2_r;
  logic signed [WIDTH:0]   s_re_r, s_im_r;
  // stage 2 registers
  logic                    v2_r;
  logic [1:0]              f2_r;
  logic                    ng_re_r, ng_im_r;
  logic [MW-1:0]           mg_re_r, mg_im_r, den_r;
  // stage 3
  logic                    v3_r;
  cau_work_t               w3_r, w3_nxt;

  logic signed [MW+1:0]    v_re, v_im;
  logic signed [MW+1:0]    a_re_abs, a_im_abs;
  logic [NW-1:0]           n_re, n_im;

  // stage 1: multipliers and short sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r    <= in_data.func;
      p_rr_r  <= MW'(in_data.a_re * in_data.b_re);
      p_ii_r  <= MW'(in_data.a_im * in_data.b_im);
      p_ri_r  <= MW'(in_data.a_re * in_data.b_im);
      p_ir_r  <= MW'(in_data.a_im * in_data.b_re);
      p_bb1_r <= MW'(in_data.b_re * in_data.b_re);
      p_bb2_r <= MW'(in_data.b_im * in_data.b_im);
      if (in_data.func == FN_SUB) begin
        s_re_r <= (WIDTH+1)'(in_data.a_re) - (WIDTH+1)'(in_data.b_re);
        s_im_r <= (WIDTH+1)'(in_data.a_im) - (WIDTH+1)'(in_data.b_im);
      end else begin
        s_re_r <= (WIDTH+1)'(in_data.a_re) + (WIDTH+1)'(in_data.b_re);
        s_im_r <= (WIDTH+1)'(in_data.a_im) + (WIDTH+1)'(in_data.b_im);
      end
    end
  end

  // stage 2: combine products, or pass sums, into signed parts and magnitudes
  always_comb begin
    case (f1_r)
      FN_MUL: begin
        v_re = (MW+2)'(p_rr_r) - (MW+2)'(p_ii_r);
        v_im = (MW+2)'(p_ri_r) + (MW+2)'(p_ir_r);
      end
      FN_DIV: begin
        v_re = (MW+2)'(p_rr_r) + (MW+2)'(p_ii_r);
        v_im = (MW+2)'(p_ir_r) - (MW+2)'(p_ri_r);
      end
      default: begin
        v_re = (MW+2)'(s_re_r);
        v_im = (MW+2)'(s_im_r);
      end
    endcase
    a_re_abs = v_re[MW+1] ? -v_re : v_re;
    a_im_abs = v_im[MW+1] ? -v_im : v_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_r    <= f1_r;
      ng_re_r <= v_re[MW+1];
      ng_im_r <= v_im[MW+1];
      mg_re_r <= a_re_abs[MW-1:0];
      mg_im_r <= a_im_abs[MW-1:0];
      den_r   <= MW'(p_bb1_r) + MW'(p_bb2_r);
    end
  end

  // stage 3: scale, overflow precheck and divider seed
  always_comb begin
    n_re = NW'(mg_re_r) << FRAC_BITS;
    n_im = NW'(mg_im_r) << FRAC_BITS;
    w3_nxt.func    = f2_r;
    w3_nxt.den     = den_r;
    w3_nxt.dz      = (f2_r == FN_DIV) && (den_r == '0);
    w3_nxt.re.neg  = ng_re_r;
    w3_nxt.im.neg  = ng_im_r;
    w3_nxt.re.over = n_re[NW-1:WIDTH] >= den_r;
    w3_nxt.im.over = n_im[NW-1:WIDTH] >= den_r;
    w3_nxt.re.rem  = {1'b0, n_re[NW-1:WIDTH]};
    w3_nxt.im.rem  = {1'b0, n_im[NW-1:WIDTH]};
    w3_nxt.re.num  = n_re[WIDTH-1:0];
    w3_nxt.im.num  = n_im[WIDTH-1:0];
    w3_nxt.re.quo  = '0;
    w3_nxt.im.quo  = '0;
    if (f2_r == FN_MUL) begin
      w3_nxt.re.mag = mg_re_r >> FRAC_BITS;
      w3_nxt.im.mag = mg_im_r >> FRAC_BITS;
    end else begin
      w3_nxt.re.mag = mg_re_r;
      w3_nxt.im.mag = mg_im_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w3_r <= w3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_work  = w3_r;

endmodule

// ===== sv/cau_div_step.sv =====
// one restoring division step for both parts, registered
module cau_div_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  cau_pkg::cau_work_t in_work,
  output logic               out_valid,
  output cau_pkg::cau_work_t out_work
);
  import cau_pkg::*;

  logic      v_r;
  cau_work_t w_r, w_nxt;
  logic [MW:0] r2_re, r2_im;
  logic        ge_re, ge_im;

  // shift in the next numerator bit and try a subtract
  always_comb begin
    w_nxt  = in_work;
    r2_re  = {in_work.re.rem[MW-1:0], in_work.re.num[WIDTH-1]};
    r2_im  = {in_work.im.rem[MW-1:0], in_work.im.num[WIDTH-1]};
    ge_re  = r2_re >= {1'b0, in_work.den};
    ge_im  = r2_im >= {1'b0, in_work.den};
    w_nxt.re.rem = ge_re ? r2_re - {1'b0, in_work.den} : r2_re;
    w_nxt.im.rem = ge_im ? r2_im - {1'b0, in_work.den} : r2_im;
    w_nxt.re.num = {in_work.re.num[WIDTH-2:0], 1'b0};
    w_nxt.im.num = {in_work.im.num[WIDTH-2:0], 1'b0};
    w_nxt.re.quo = {in_work.re.quo[WIDTH-2:0], ge_re};
    w_nxt.im.quo = {in_work.im.quo[WIDTH-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_work  = w_r;

endmodule

// ===== sv/cau_final.sv =====
// result select, saturation and output register
module cau_final (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  cau_pkg::cau_work_t in_work,
  output logic               out_valid,
  output cau_pkg::cau_out_t  out_data
);
  import cau_pkg::*;

  localparam logic [MW-1:0] LIM_POS = MW'((1 << (WIDTH - 1)) - 1);
  localparam logic [MW-1:0] LIM_NEG = MW'(1 << (WIDTH - 1));

  logic     v_r;
  cau_out_t o_r, o_nxt;
  logic [MW-1:0] q_re, q_im, lim_re, lim_im, fin_re, fin_im;
  logic          sat_re, sat_im, is_div;

  // clip each part to the signed range
  always_comb begin
    is_div = in_work.func == FN_DIV;
    q_re   = is_div ? MW'(in_work.re.quo) : in_work.re.mag;
    q_im   = is_div ? MW'(in_work.im.quo) : in_work.im.mag;
    lim_re = in_work.re.neg ? LIM_NEG : LIM_POS;
    lim_im = in_work.im.neg ? LIM_NEG : LIM_POS;
    sat_re = (is_div && in_work.re.over) || (q_re > lim_re);
    sat_im = (is_div && in_work.im.over) || (q_im > lim_im);
    fin_re = sat_re ? lim_re : q_re;
    fin_im = sat_im ? lim_im : q_im;
    if (in_work.re.neg) fin_re = -fin_re;
    if (in_work.im.neg) fin_im = -fin_im;
    if (in_work.dz) begin
      o_nxt.res_re    = '0;
      o_nxt.res_im    = '0;
      o_nxt.saturated = 1'b0;
      o_nxt.div_zero  = 1'b1;
    end else begin
      o_nxt.res_re    = fin_re[WIDTH-1:0];
      o_nxt.res_im    = fin_im[WIDTH-1:0];
      o_nxt.saturated = sat_re || sat_im;
      o_nxt.div_zero  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = o_r;

endmodule

// ===== sv/complex_arith_unit.sv =====
// top level of the pipelined complex add, subtract, multiply and divide unit
//
// Input channel in_valid/in_stall/in_data carries an operation code and two
// complex Q7.8 operands; output channel out_valid/out_stall/out_data returns
// the result parts with saturated and div_zero flags, one per transaction.
// The pipeline is three front stages (multipliers, sums, divider seed),
// 16 restoring divide stages that produce one quotient bit each, and the
// saturating output register. All operations go through the same stages, so
// results leave in order. Throughput is one transaction per cycle while not stalled.
// When out_stall is high while a result is presented, the whole pipeline
// holds and in_stall rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset clears every stage's valid bit; data registers keep
// whatever they held.
module complex_arith_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cau_pkg::cau_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cau_pkg::cau_out_t out_data
);
  import cau_pkg::*;

  logic      en;
  logic      dv   [WIDTH+1];
  cau_work_t dw   [WIDTH+1];

  // pipeline advances unless the output is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  cau_prep #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (dv[0]),
    .out_work  (dw[0])
  );

  // divide stages
  for (genvar g = 0; g < WIDTH; g++) begin : g_div
    cau_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv[g]),
      .in_work   (dw[g]),
      .out_valid (dv[g+1]),
      .out_work  (dw[g+1])
    );
  end

  cau_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv[WIDTH]),
    .in_work   (dw[WIDTH]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // divide by zero gives zero parts and no saturation
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_zero |->
      out_data.res_re == '0 && out_data.res_im == '0 && !out_data.saturated)
    else $error("div_zero result not cleared");

  // saturation leaves at least one part at a limit
  a_sat_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.res_re == {1'b0, {(WIDTH-1){1'b1}}} ||
      out_data.res_re == {1'b1, {(WIDTH-1){1'b0}}} ||
      out_data.res_im == {1'b0, {(WIDTH-1){1'b1}}} ||
      out_data.res_im == {1'b1, {(WIDTH-1){1'b0}}})
    else $error("saturated flag without a clipped part");

  // input is held exactly while a presented result is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
